FILE: hdl/rwta_pkg.sv
// ============================================================================
// rwta_pkg
// shared types, widths, codes and defaults of the wall texel addresser
// ============================================================================
`default_nettype none

package rwta_pkg;

    // default values of the top level parameters
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ROW_BITS_DEF      = 12;

    // fixed point of the ray direction components
    localparam int DIR_BITS = 14;

    // field widths
    localparam int POS_W    = 22;
    localparam int DIR_W    = 16;
    localparam int TEX_W    = 11;
    localparam int WIN_W    = 12;
    localparam int HEIGHT_W = 16;
    localparam int SCR_W    = 12;
    localparam int TCOL_W   = 10;
    localparam int ADDR_W   = 20;
    localparam int TP_W     = 32;
    localparam int BASE_W   = 18;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT  = 3'd4;

    // register reset values
    localparam logic [TEX_W-1:0] TEX_WIDTH_RST  = 11'd64;
    localparam logic [TEX_W-1:0] TEX_HEIGHT_RST = 11'd64;
    localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 12'd720;

    // request kinds
    typedef enum logic {
        REQ_COLUMN = 1'b0,
        REQ_PIXEL  = 1'b1
    } t_req;

    // wall texture codes
    typedef enum logic [1:0] {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_EAST  = 2'd2,
        TEX_WEST  = 2'd3
    } t_tex;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALL_MUL,
        ST_WALL_ADD,
        ST_COL_MUL,
        ST_COL_FIX,
        ST_DIV_WAIT,
        ST_POS_MUL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_col;
        logic pix_step;
        logic wall_mul;
        logic wall_add;
        logic col_mul;
        logic col_fix;
        logic pos_mul;
    } t_cmd;

    // datapath and output buffer to controller
    typedef struct packed {
        logic div_busy;
        logic skid_full;
    } t_stat;

    // one result beat
    typedef struct packed {
        logic [SCR_W-1:0]  pixel_row;
        logic [SCR_W-1:0]  pixel_column;
        logic [ADDR_W-1:0] texel_address;
        logic [1:0]        wall_texture;
        logic              column_done;
    } t_pixel;

endpackage

`default_nettype wire

FILE: hdl/rwta_req_if.sv
// ============================================================================
// rwta_req_if
// request channel: column set-up and pixel beats
// ============================================================================
`default_nettype none

interface rwta_req_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       req_type;
    logic                                       hit_side;
    logic signed [rwta_pkg::DIR_W-1:0]          ray_dir_x;
    logic signed [rwta_pkg::DIR_W-1:0]          ray_dir_y;
    logic        [rwta_pkg::POS_W-1:0]          wall_distance;
    logic        [rwta_pkg::HEIGHT_W-1:0]       wall_height;
    logic        [rwta_pkg::SCR_W-1:0]          first_row;
    logic        [rwta_pkg::SCR_W-1:0]          stop_row;
    logic        [rwta_pkg::SCR_W-1:0]          screen_column;

    modport source (
        output valid, req_type, hit_side, ray_dir_x, ray_dir_y, wall_distance,
               wall_height, first_row, stop_row, screen_column,
        input  ready
    );

    modport sink (
        input  valid, req_type, hit_side, ray_dir_x, ray_dir_y, wall_distance,
               wall_height, first_row, stop_row, screen_column,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/rwta_pix_if.sv
// ============================================================================
// rwta_pix_if
// result channel: one texel address beat per drawn pixel
// ============================================================================
`default_nettype none

interface rwta_pix_if;
    logic                              valid;
    logic                              ready;
    logic [rwta_pkg::SCR_W-1:0]        pixel_row;
    logic [rwta_pkg::SCR_W-1:0]        pixel_column;
    logic [rwta_pkg::ADDR_W-1:0]       texel_address;
    logic [1:0]                        wall_texture;
    logic                              column_done;

    modport source (
        output valid, pixel_row, pixel_column, texel_address, wall_texture, column_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_row, pixel_column, texel_address, wall_texture, column_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/rwta_div.sv
// ============================================================================
// rwta_div
// restoring divider, one quotient bit per cycle
// ============================================================================
`default_nettype none

module rwta_div #(
    parameter int NQ = 27,
    parameter int DV = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NQ-1:0] i_dividend,
    input  wire logic [DV-1:0] i_divisor,
    output logic               o_busy,
    output logic [NQ-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(NQ + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DV-1:0]    r_rem;
    logic [NQ-1:0]    r_quo;
    logic [DV-1:0]    r_dvs;

    logic [DV:0]      w_shift;
    logic [DV+1:0]    w_diff;

    // trial subtract of the divisor from the shifted remainder
    assign w_shift = {r_rem, r_quo[NQ-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NQ);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[DV+1]) begin
                r_rem <= w_diff[DV-1:0];
                r_quo <= {r_quo[NQ-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DV-1:0];
                r_quo <= {r_quo[NQ-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: hdl/rwta_dp.sv
// ============================================================================
// rwta_dp
// datapath: config registers, column set-up arithmetic and pixel stepping
// ============================================================================
`default_nettype none

module rwta_dp #(
    parameter int FRACTION_BITS = rwta_pkg::FRACTION_BITS_DEF,
    parameter int ROW_BITS      = rwta_pkg::ROW_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rwta_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [rwta_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire rwta_pkg::t_cmd                        i_cmd,
    input  wire logic                                  i_hit_side,
    input  wire logic signed [rwta_pkg::DIR_W-1:0]     i_ray_dir_x,
    input  wire logic signed [rwta_pkg::DIR_W-1:0]     i_ray_dir_y,
    input  wire logic [rwta_pkg::POS_W-1:0]            i_wall_distance,
    input  wire logic [rwta_pkg::HEIGHT_W-1:0]         i_wall_height,
    input  wire logic [rwta_pkg::SCR_W-1:0]            i_first_row,
    input  wire logic [rwta_pkg::SCR_W-1:0]            i_stop_row,
    input  wire logic [rwta_pkg::SCR_W-1:0]            i_screen_column,
    output logic                                       o_div_busy,
    output logic                                       o_push,
    output rwta_pkg::t_pixel                           o_pix
);

    localparam int FB     = FRACTION_BITS + rwta_pkg::DIR_BITS;
    localparam int NQ     = rwta_pkg::TEX_W + FRACTION_BITS;
    localparam int DV     = rwta_pkg::HEIGHT_W;
    localparam int PROD_W = rwta_pkg::POS_W + 1 + rwta_pkg::DIR_W;
    localparam int WALL_W = PROD_W + 1;
    localparam int TXP_W  = FB + rwta_pkg::TEX_W;
    localparam int MADDR_W = 2 * rwta_pkg::TEX_W;

    // configuration registers
    logic [rwta_pkg::POS_W-1:0] r_px;
    logic [rwta_pkg::POS_W-1:0] r_py;
    logic [rwta_pkg::TEX_W-1:0] r_tw;
    logic [rwta_pkg::TEX_W-1:0] r_th;
    logic [rwta_pkg::WIN_W-1:0] r_wh;

    // column set-up operands
    logic [rwta_pkg::POS_W-1:0]        r_pos;
    logic signed [rwta_pkg::DIR_W-1:0] r_comp;
    logic [rwta_pkg::POS_W-1:0]        r_dist;
    logic                              r_mirror;
    logic signed [PROD_W-1:0]          r_prod;
    logic [FB-1:0]                     r_frac;
    logic [TXP_W-1:0]                  r_txp;
    logic signed [rwta_pkg::BASE_W-1:0] r_base;

    // column state
    logic [rwta_pkg::TCOL_W-1:0] r_texel_col;
    logic [rwta_pkg::TP_W-1:0]   r_tex_pos;
    logic [rwta_pkg::TP_W-1:0]   r_row_step;
    logic [ROW_BITS-1:0]         r_cur_row;
    logic [ROW_BITS-1:0]         r_end_row;
    logic [rwta_pkg::SCR_W-1:0]  r_cur_col;
    rwta_pkg::t_tex              r_tex;
    logic                        r_col_active;

    logic [rwta_pkg::BASE_W-1:0] w_base;
    logic [ROW_BITS-1:0]         w_first;
    logic [ROW_BITS-1:0]         w_stop;
    logic [WALL_W-1:0]           w_wall;
    logic [rwta_pkg::TEX_W-1:0]  w_tx;
    logic [rwta_pkg::TEX_W-1:0]  w_txm;
    logic [NQ-1:0]               w_quo;
    logic [rwta_pkg::TP_W-1:0]   w_step32;
    logic [rwta_pkg::TP_W-1:0]   w_base32;
    logic [rwta_pkg::TEX_W-1:0]  w_mask;
    logic [rwta_pkg::TEX_W-1:0]  w_ty;
    logic [MADDR_W-1:0]          w_addr;
    logic [ROW_BITS-1:0]         w_next_row;
    logic                        w_done;
    logic [DV-1:0]               w_divisor;
    logic                        w_step;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_tw <= rwta_pkg::TEX_WIDTH_RST;
            r_th <= rwta_pkg::TEX_HEIGHT_RST;
            r_wh <= rwta_pkg::WIN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rwta_pkg::CFG_PLAYER_X:       r_px <= i_cfg_data;
                rwta_pkg::CFG_PLAYER_Y:       r_py <= i_cfg_data;
                rwta_pkg::CFG_TEXTURE_WIDTH:  r_tw <= i_cfg_data[rwta_pkg::TEX_W-1:0];
                rwta_pkg::CFG_TEXTURE_HEIGHT: r_th <= i_cfg_data[rwta_pkg::TEX_W-1:0];
                rwta_pkg::CFG_WINDOW_HEIGHT:  r_wh <= i_cfg_data[rwta_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // set-up combinational terms
    assign w_base = rwta_pkg::BASE_W'(i_first_row)
                  - rwta_pkg::BASE_W'(r_wh >> 1)
                  + rwta_pkg::BASE_W'(i_wall_height >> 1);
    assign w_first   = ROW_BITS'(i_first_row);
    assign w_stop    = ROW_BITS'(i_stop_row);
    assign w_divisor = (i_wall_height == '0) ? DV'(1) : i_wall_height;

    // wall hit position, only the fraction bits are kept
    assign w_wall = (WALL_W'(r_pos) << rwta_pkg::DIR_BITS) + WALL_W'(r_prod);

    // texel column and its mirror
    assign w_tx  = r_txp[FB +: rwta_pkg::TEX_W];
    assign w_txm = r_tw - w_tx - 1'b1;

    assign w_step32 = rwta_pkg::TP_W'(w_quo);
    assign w_base32 = rwta_pkg::TP_W'(r_base);

    // per-pixel address
    assign w_mask = (r_th == '0) ? '0 : r_th - 1'b1;
    assign w_ty   = rwta_pkg::TEX_W'(r_tex_pos >> FRACTION_BITS) & w_mask;
    assign w_addr = MADDR_W'(r_th) * MADDR_W'(w_ty) + MADDR_W'(r_texel_col);

    assign w_next_row = r_cur_row + 1'b1;
    assign w_done     = (w_next_row >= r_end_row) || (w_next_row == '0);
    assign w_step     = i_cmd.pix_step && r_col_active;

    rwta_div #(
        .NQ (NQ),
        .DV (DV)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load_col),
        .i_dividend ({r_th, {FRACTION_BITS{1'b0}}}),
        .i_divisor  (w_divisor),
        .o_busy     (o_div_busy),
        .o_quotient (w_quo)
    );

    // set-up pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_col) begin
            r_pos    <= i_hit_side ? r_px : r_py;
            r_comp   <= i_hit_side ? i_ray_dir_x : i_ray_dir_y;
            r_dist   <= i_wall_distance;
            r_mirror <= (!i_hit_side && (i_ray_dir_x > 0))
                     || (i_hit_side && (i_ray_dir_y < 0));
            r_base   <= $signed(w_base);
        end
        if (i_cmd.wall_mul) begin
            r_prod <= $signed({1'b0, r_dist}) * r_comp;
        end
        if (i_cmd.wall_add) begin
            r_frac <= w_wall[FB-1:0];
        end
        if (i_cmd.col_mul) begin
            r_txp <= TXP_W'(r_frac) * TXP_W'(r_tw);
        end
    end

    // column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_texel_col  <= '0;
            r_tex_pos    <= '0;
            r_row_step   <= '0;
            r_cur_row    <= '0;
            r_end_row    <= '0;
            r_cur_col    <= '0;
            r_tex        <= rwta_pkg::TEX_NORTH;
            r_col_active <= 1'b0;
        end else begin
            if (i_cmd.load_col) begin
                r_cur_row    <= w_first;
                r_end_row    <= w_stop;
                r_cur_col    <= i_screen_column;
                r_col_active <= (w_first < w_stop);
                // a zero component keeps the previous texture
                if (i_hit_side) begin
                    if (i_ray_dir_y < 0) begin
                        r_tex <= rwta_pkg::TEX_NORTH;
                    end else if (i_ray_dir_y > 0) begin
                        r_tex <= rwta_pkg::TEX_SOUTH;
                    end
                end else begin
                    if (i_ray_dir_x > 0) begin
                        r_tex <= rwta_pkg::TEX_EAST;
                    end else if (i_ray_dir_x < 0) begin
                        r_tex <= rwta_pkg::TEX_WEST;
                    end
                end
            end
            if (i_cmd.col_fix) begin
                r_texel_col <= rwta_pkg::TCOL_W'(r_mirror ? w_txm : w_tx);
            end
            if (i_cmd.pos_mul) begin
                r_row_step <= w_step32;
                r_tex_pos  <= w_base32 * w_step32;
            end
            if (w_step) begin
                r_tex_pos <= r_tex_pos + r_row_step;
                r_cur_row <= w_next_row;
                if (w_done) begin
                    r_col_active <= 1'b0;
                end
            end
        end
    end

    // result beat
    assign o_push               = w_step;
    assign o_pix.pixel_row      = rwta_pkg::SCR_W'(r_cur_row);
    assign o_pix.pixel_column   = r_cur_col;
    assign o_pix.texel_address  = rwta_pkg::ADDR_W'(w_addr);
    assign o_pix.wall_texture   = r_tex;
    assign o_pix.column_done    = w_done;

endmodule

`default_nettype wire

FILE: hdl/rwta_obuf.sv
// ============================================================================
// rwta_obuf
// output register with skid stage for result beats
// ============================================================================
`default_nettype none

module rwta_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rwta_pkg::t_pixel  i_data,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output rwta_pkg::t_pixel       o_data,
    output logic                   o_full
);

    logic             r_out_v;
    logic             r_skid_v;
    rwta_pkg::t_pixel r_out;
    rwta_pkg::t_pixel r_skid;
    logic             w_free;

    // output register is free when empty or taken this cycle
    assign w_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= i_push;
            end else begin
                r_out_v  <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // beat data, skid drains first to keep order
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign o_full  = r_skid_v;

    // skid only holds a beat behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a beat while output is empty");

    // no beat arrives while the skid stage is occupied
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_v)
        else $error("result pushed into a full output buffer");

endmodule

`default_nettype wire

FILE: hdl/rwta_ctrl.sv
// ============================================================================
// rwta_ctrl
// controller: request handshake and column set-up sequence
// ============================================================================
`default_nettype none

module rwta_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_req_type,
    input  wire rwta_pkg::t_stat i_stat,
    output logic                 o_ready,
    output rwta_pkg::t_cmd       o_cmd
);

    rwta_pkg::t_state r_state;
    rwta_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_valid && o_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwta_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            rwta_pkg::ST_IDLE: begin
                o_ready = !i_stat.skid_full;
                if (i_valid && !i_stat.skid_full) begin
                    if (i_req_type == rwta_pkg::REQ_COLUMN) begin
                        o_cmd.load_col = 1'b1;
                        n_state        = rwta_pkg::ST_WALL_MUL;
                    end else begin
                        o_cmd.pix_step = 1'b1;
                    end
                end
            end
            rwta_pkg::ST_WALL_MUL: begin
                o_cmd.wall_mul = 1'b1;
                n_state        = rwta_pkg::ST_WALL_ADD;
            end
            rwta_pkg::ST_WALL_ADD: begin
                o_cmd.wall_add = 1'b1;
                n_state        = rwta_pkg::ST_COL_MUL;
            end
            rwta_pkg::ST_COL_MUL: begin
                o_cmd.col_mul = 1'b1;
                n_state       = rwta_pkg::ST_COL_FIX;
            end
            rwta_pkg::ST_COL_FIX: begin
                o_cmd.col_fix = 1'b1;
                n_state       = rwta_pkg::ST_DIV_WAIT;
            end
            rwta_pkg::ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = rwta_pkg::ST_POS_MUL;
                end
            end
            rwta_pkg::ST_POS_MUL: begin
                o_cmd.pos_mul = 1'b1;
                n_state       = rwta_pkg::ST_IDLE;
            end
            default: begin
                n_state = rwta_pkg::ST_IDLE;
            end
        endcase
    end

    // a column beat always starts the set-up sequence
    a_col_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == rwta_pkg::REQ_COLUMN)
            |=> r_state == rwta_pkg::ST_WALL_MUL)
        else $error("column beat did not start set-up");

    // texture position is only formed from a finished quotient
    a_quo_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rwta_pkg::ST_POS_MUL |-> !i_stat.div_busy)
        else $error("row step used while divider busy");

endmodule

`default_nettype wire

FILE: hdl/raycast_wall_texel_addresser_unit.sv
// ============================================================================
// raycast_wall_texel_addresser_unit
// turns a wall column hit into one texel address per drawn screen row
// ============================================================================
// usage
//   i_req carries request beats. a column beat (req_type 0) sets up a wall
//   column; each pixel beat (req_type 1) then gives one result beat on o_pix
//   for the next row, with column_done on the last row. a pixel beat with no
//   column open gives nothing. configuration is written on i_cfg_we with
//   i_cfg_idx / i_cfg_data while the block is idle.
//   a pixel beat's result goes into the output register, or into the skid
//   stage while one waits; pixels run at one per cycle while o_pix is taken.
//   a column beat holds the request side while the set-up runs: wall
//   multiply, wall add, texel column multiply and fix, a wait for the
//   restoring divider, which gives one quotient bit per cycle over
//   11 + FRACTION_BITS bits for the row step, and the start position
//   multiply; the accepting cycle starts the divider.
//   the output register plus one skid stage let a pixel beat be taken while
//   a result waits; when both are full the request side stalls until the
//   receiver takes a beat.
//   synchronous reset clears the open column and the texture choice (north)
//   and loads the register defaults.
// ============================================================================
`default_nettype none

module raycast_wall_texel_addresser_unit #(
    parameter int FRACTION_BITS = rwta_pkg::FRACTION_BITS_DEF,
    parameter int ROW_BITS      = rwta_pkg::ROW_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rwta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rwta_req_if.sink                             i_req,
    rwta_pix_if.source                           o_pix
);

    rwta_pkg::t_cmd   w_cmd;
    rwta_pkg::t_stat  w_stat;
    rwta_pkg::t_pixel w_res;
    rwta_pkg::t_pixel w_out;
    logic             w_push;
    logic             w_div_busy;
    logic             w_full;
    logic             w_ready;

    assign w_stat.div_busy  = w_div_busy;
    assign w_stat.skid_full = w_full;
    assign i_req.ready      = w_ready;

    // sequencer
    rwta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_stat     (w_stat),
        .o_ready    (w_ready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and column state
    rwta_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .ROW_BITS      (ROW_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_hit_side      (i_req.hit_side),
        .i_ray_dir_x     (i_req.ray_dir_x),
        .i_ray_dir_y     (i_req.ray_dir_y),
        .i_wall_distance (i_req.wall_distance),
        .i_wall_height   (i_req.wall_height),
        .i_first_row     (i_req.first_row),
        .i_stop_row      (i_req.stop_row),
        .i_screen_column (i_req.screen_column),
        .o_div_busy      (w_div_busy),
        .o_push          (w_push),
        .o_pix           (w_res)
    );

    // result buffering
    rwta_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_ready (o_pix.ready),
        .o_valid (o_pix.valid),
        .o_data  (w_out),
        .o_full  (w_full)
    );

    assign o_pix.pixel_row     = w_out.pixel_row;
    assign o_pix.pixel_column  = w_out.pixel_column;
    assign o_pix.texel_address = w_out.texel_address;
    assign o_pix.wall_texture  = w_out.wall_texture;
    assign o_pix.column_done   = w_out.column_done;

endmodule

`default_nettype wire

FILE: tb/raycast_wall_texel_addresser_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// raycast_wall_texel_addresser_unit_test
// self-checking bench for the wall texel addresser. column and pixel beats
// go in on the request channel; a scoreboard with its own fixed point copy of
// the column set-up and pixel stepping predicts each result beat, which is
// compared field by field. the run moves through several register settings,
// extremes included, with random idling on both channels.
// ============================================================================

module raycast_wall_texel_addresser_unit_test;

    localparam int FRAC          = rwta_pkg::FRACTION_BITS_DEF;
    localparam int WALL_FRAC     = FRAC + rwta_pkg::DIR_BITS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_PIXELS    = 40;

    // one request beat as the bench sees it
    typedef struct packed {
        rwta_pkg::t_req                  req_type;
        logic                            hit_side;
        logic [rwta_pkg::DIR_W-1:0]      ray_dir_x;
        logic [rwta_pkg::DIR_W-1:0]      ray_dir_y;
        logic [rwta_pkg::POS_W-1:0]      wall_distance;
        logic [rwta_pkg::HEIGHT_W-1:0]   wall_height;
        logic [rwta_pkg::SCR_W-1:0]      first_row;
        logic [rwta_pkg::SCR_W-1:0]      stop_row;
        logic [rwta_pkg::SCR_W-1:0]      screen_column;
    } t_req_beat;

    // predicts texel address beats and checks the ones that come out
    class texel_scoreboard;
        // register copies
        logic [rwta_pkg::POS_W-1:0]  player_x;
        logic [rwta_pkg::POS_W-1:0]  player_y;
        logic [rwta_pkg::TEX_W-1:0]  tex_width;
        logic [rwta_pkg::TEX_W-1:0]  tex_height;
        logic [rwta_pkg::WIN_W-1:0]  screen_rows;
        // open column
        logic [rwta_pkg::TCOL_W-1:0] texel_col;
        logic [rwta_pkg::TP_W-1:0]   tex_pos;
        logic [rwta_pkg::TP_W-1:0]   row_step;
        logic [rwta_pkg::SCR_W-1:0]  cur_row;
        logic [rwta_pkg::SCR_W-1:0]  end_row;
        logic [rwta_pkg::SCR_W-1:0]  cur_col;
        rwta_pkg::t_tex              choice;
        bit                          col_open;
        rwta_pkg::t_pixel            pending[$];
        int                          fails;

        function new();
            player_x    = '0;
            player_y    = '0;
            tex_width   = rwta_pkg::TEX_WIDTH_RST;
            tex_height  = rwta_pkg::TEX_HEIGHT_RST;
            screen_rows = rwta_pkg::WIN_HEIGHT_RST;
            texel_col   = '0;
            tex_pos     = '0;
            row_step    = '0;
            cur_row     = '0;
            end_row     = '0;
            cur_col     = '0;
            choice      = rwta_pkg::TEX_NORTH;
            col_open    = 1'b0;
            fails       = 0;
        endfunction

        function void set_register(logic [rwta_pkg::CFG_IDX_W-1:0] idx,
                                   logic [rwta_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rwta_pkg::CFG_PLAYER_X:       player_x    = data[rwta_pkg::POS_W-1:0];
                rwta_pkg::CFG_PLAYER_Y:       player_y    = data[rwta_pkg::POS_W-1:0];
                rwta_pkg::CFG_TEXTURE_WIDTH:  tex_width   = data[rwta_pkg::TEX_W-1:0];
                rwta_pkg::CFG_TEXTURE_HEIGHT: tex_height  = data[rwta_pkg::TEX_W-1:0];
                rwta_pkg::CFG_WINDOW_HEIGHT:  screen_rows = data[rwta_pkg::WIN_W-1:0];
                default: ;
            endcase
        endfunction

        // column beats set up the column, pixel beats queue one expected result while a column is open
        function void note_request(t_req_beat b);
            longint           pos_v, comp, wall, base, prod;
            logic [63:0]      frac, tx, num, den, quot, addr;
            logic [31:0]      mask, ty;
            rwta_pkg::t_pixel want;

            if (b.req_type == rwta_pkg::REQ_COLUMN) begin
                // wall hit fraction and texel column
                pos_v = b.hit_side ? longint'(player_x) : longint'(player_y);
                comp  = b.hit_side ? longint'($signed(b.ray_dir_x))
                                   : longint'($signed(b.ray_dir_y));
                wall  = (pos_v <<< rwta_pkg::DIR_BITS) + longint'(b.wall_distance) * comp;
                frac  = wall & ((64'd1 << WALL_FRAC) - 64'd1);
                tx    = (frac * {53'd0, tex_width}) >> WALL_FRAC;
                if ((!b.hit_side && $signed(b.ray_dir_x) > 0) ||
                    (b.hit_side && $signed(b.ray_dir_y) < 0)) begin
                    tx = {53'd0, tex_width} - tx - 64'd1;
                end
                texel_col = tx[rwta_pkg::TCOL_W-1:0];

                // texture pick, a zero component keeps the last one
                if (b.hit_side) begin
                    if ($signed(b.ray_dir_y) < 0)      choice = rwta_pkg::TEX_NORTH;
                    else if ($signed(b.ray_dir_y) > 0) choice = rwta_pkg::TEX_SOUTH;
                end else begin
                    if ($signed(b.ray_dir_x) > 0)      choice = rwta_pkg::TEX_EAST;
                    else if ($signed(b.ray_dir_x) < 0) choice = rwta_pkg::TEX_WEST;
                end

                // vertical step and start position
                num      = {53'd0, tex_height} << FRAC;
                den      = (b.wall_height == '0) ? 64'd1 : {48'd0, b.wall_height};
                quot     = num / den;
                row_step = quot[31:0];
                base     = longint'(b.first_row) - longint'(screen_rows / 2)
                         + longint'(b.wall_height / 2);
                prod     = base * longint'(row_step);
                tex_pos  = prod[31:0];

                cur_row  = b.first_row;
                end_row  = b.stop_row;
                cur_col  = b.screen_column;
                col_open = cur_row < end_row;
            end else if (col_open) begin
                mask    = (tex_height == '0) ? 32'd0 : {21'd0, tex_height} - 32'd1;
                ty      = (tex_pos >> FRAC) & mask;
                tex_pos = tex_pos + row_step;
                addr    = {53'd0, tex_height} * {32'd0, ty} + {54'd0, texel_col};

                want.pixel_row     = cur_row;
                want.pixel_column  = cur_col;
                want.texel_address = addr[rwta_pkg::ADDR_W-1:0];
                want.wall_texture  = choice;
                cur_row            = cur_row + 12'd1;
                want.column_done   = (cur_row >= end_row) || (cur_row == '0);
                if (want.column_done) col_open = 1'b0;
                pending.push_back(want);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_pixel(rwta_pkg::t_pixel got);
            rwta_pkg::t_pixel want;

            if (pending.size() == 0) begin
                $error("result beat with nothing expected: row %0d column %0d",
                       got.pixel_row, got.pixel_column);
                fails++;
                return;
            end
            want = pending.pop_front();
            compare_field("pixel_row", want.pixel_row, got.pixel_row);
            compare_field("pixel_column", want.pixel_column, got.pixel_column);
            compare_field("texel_address", want.texel_address, got.texel_address);
            compare_field("wall_texture", want.wall_texture, got.wall_texture);
            compare_field("column_done", want.column_done, got.column_done);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rwta_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rwta_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rwta_req_if req_bus ();
    rwta_pix_if pix_bus ();

    texel_scoreboard board = new();
    bit              idling_on = 1'b1;
    int unsigned     cycle_count = 0;

    raycast_wall_texel_addresser_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_pix      (pix_bus)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("raycast_wall_texel_addresser_unit test failed");
            $finish;
        end
    end

    // receiver: checks each taken beat, stalls in random bursts while idling is on
    initial begin
        int               stall_left;
        rwta_pkg::t_pixel got;

        stall_left = 0;
        pix_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_bus.valid && pix_bus.ready) begin
                got = {pix_bus.pixel_row, pix_bus.pixel_column, pix_bus.texel_address,
                       pix_bus.wall_texture, pix_bus.column_done};
                board.check_pixel(got);
            end
            if (stall_left > 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
            pix_bus.ready <= (stall_left == 0) && i_rst_n;
        end
    end

    // one register write, enable left high for the next one
    task automatic write_register(input logic [rwta_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[rwta_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        board.set_register(idx, value[rwta_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic set_registers(input int unsigned px, input int unsigned py,
                                 input int unsigned tw, input int unsigned th,
                                 input int unsigned wh);
        write_register(rwta_pkg::CFG_PLAYER_X, px);
        write_register(rwta_pkg::CFG_PLAYER_Y, py);
        write_register(rwta_pkg::CFG_TEXTURE_WIDTH, tw);
        write_register(rwta_pkg::CFG_TEXTURE_HEIGHT, th);
        write_register(rwta_pkg::CFG_WINDOW_HEIGHT, wh);
        i_cfg_we <= 1'b0;
    endtask

    // send one request beat, with an occasional gap in front of it
    task automatic push_request(input t_req_beat b);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= b.req_type;
        req_bus.hit_side      <= b.hit_side;
        req_bus.ray_dir_x     <= b.ray_dir_x;
        req_bus.ray_dir_y     <= b.ray_dir_y;
        req_bus.wall_distance <= b.wall_distance;
        req_bus.wall_height   <= b.wall_height;
        req_bus.first_row     <= b.first_row;
        req_bus.stop_row      <= b.stop_row;
        req_bus.screen_column <= b.screen_column;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        board.note_request(b);
    endtask

    function automatic t_req_beat random_bits();
        logic [127:0] r;

        r = {$urandom, $urandom, $urandom, $urandom};
        return r[$bits(t_req_beat)-1:0];
    endfunction

    // pixel beat with junk in the ignored fields
    task automatic push_pixels(input int count);
        t_req_beat b;

        repeat (count) begin
            b = random_bits();
            b.req_type = rwta_pkg::REQ_PIXEL;
            push_request(b);
        end
    endtask

    task automatic push_column(input logic side, input logic [15:0] rx, input logic [15:0] ry,
                               input logic [21:0] wall_dist, input logic [15:0] height,
                               input logic [11:0] first, input logic [11:0] stop,
                               input logic [11:0] col);
        t_req_beat b;

        b.req_type      = rwta_pkg::REQ_COLUMN;
        b.hit_side      = side;
        b.ray_dir_x     = rx;
        b.ray_dir_y     = ry;
        b.wall_distance = wall_dist;
        b.wall_height   = height;
        b.first_row     = first;
        b.stop_row      = stop;
        b.screen_column = col;
        push_request(b);
    endtask

    function automatic t_req_beat random_column();
        t_req_beat   b;
        logic [31:0] r;
        int unsigned len;

        b = random_bits();
        b.req_type = rwta_pkg::REQ_COLUMN;
        // zero and extreme ray components now and then
        case ($urandom_range(0, 9))
            0: b.ray_dir_x = '0;
            1: b.ray_dir_y = '0;
            2: begin
                b.ray_dir_x = 16'h8000;
                b.ray_dir_y = 16'h7FFF;
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 1 << 18);
            b.wall_distance = r[rwta_pkg::POS_W-1:0];
        end
        case ($urandom_range(0, 3))
            0: r = $urandom_range(1, 64);
            1: r = $urandom_range(1, 2000);
            default: r = $urandom_range(1, 65535);
        endcase
        b.wall_height = r[rwta_pkg::HEIGHT_W-1:0];
        // mostly short spans, sometimes empty, long or arbitrary
        case ($urandom_range(0, 19))
            0: len = 0;
            1: len = 4096;
            2: len = $urandom_range(9, MAX_PIXELS);
            default: len = $urandom_range(1, 8);
        endcase
        if (len < 4096) begin
            r = b.first_row + len;
            b.stop_row = (r > 4095) ? 12'd4095 : r[rwta_pkg::SCR_W-1:0];
        end
        return b;
    endfunction

    // well-formed columns with random content, some cut short or overrun
    task automatic run_columns(input int items);
        t_req_beat b;
        int        sent;
        int        rows;
        int        count;

        sent = 0;
        while (sent < items) begin
            b = random_column();
            push_request(b);
            rows = (b.first_row < b.stop_row) ? int'(b.stop_row) - int'(b.first_row) : 0;
            if (rows > MAX_PIXELS) rows = MAX_PIXELS;
            case ($urandom_range(0, 19))
                0, 1: count = (rows > 1) ? $urandom_range(0, rows - 1) : rows;
                2: count = rows + $urandom_range(1, 3);
                default: count = rows;
            endcase
            push_pixels(count);
            sent += 1 + count;
        end
    endtask

    // let every result drain and the divider go quiet
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= '0;
        i_cfg_data            <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= rwta_pkg::REQ_COLUMN;
        req_bus.hit_side      <= 1'b0;
        req_bus.ray_dir_x     <= '0;
        req_bus.ray_dir_y     <= '0;
        req_bus.wall_distance <= '0;
        req_bus.wall_height   <= '0;
        req_bus.first_row     <= '0;
        req_bus.stop_row      <= '0;
        req_bus.screen_column <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the register defaults
        push_pixels(1);                      // no column open yet
        push_column(1'b1, 16'd8192, -16'sd8192, 22'h018000, 16'd300, 12'd0, 12'd3, 12'd0);
        push_pixels(3);                      // north, mirrored
        push_column(1'b1, -16'sd8192, 16'd8192, 22'h024000, 16'd40, 12'd200, 12'd201, 12'd1);
        push_pixels(1);                      // south
        push_column(1'b0, 16'd8192, 16'd100, 22'h00C000, 16'd720, 12'd0, 12'd1, 12'd2);
        push_pixels(1);                      // east, mirrored
        push_column(1'b0, -16'sd8192, -16'sd100, 22'h00C000, 16'd720, 12'd5, 12'd6, 12'd3);
        push_pixels(1);                      // west
        push_column(1'b0, 16'd0, 16'd5000, 22'h030000, 16'd64, 12'd300, 12'd301, 12'd4);
        push_pixels(1);                      // zero x keeps west
        push_column(1'b1, 16'd300, 16'd0, 22'h030000, 16'd64, 12'd300, 12'd301, 12'd5);
        push_pixels(1);                      // zero y keeps west
        push_column(1'b0, 16'd8192, 16'd8192, 22'h010000, 16'd100, 12'd10, 12'd10, 12'd6);
        push_pixels(1);                      // empty column
        push_column(1'b1, 16'h8000, 16'h7FFF, 22'h3FFFFF, 16'd0, 12'd4094, 12'd4095, 12'd4095);
        push_pixels(1);                      // zero line height, field extremes
        push_column(1'b0, 16'h7FFF, 16'h8000, 22'd0, 16'hFFFF, 12'd100, 12'd104, 12'd7);
        push_pixels(2);                      // left unfinished
        push_column(1'b1, 16'd1, 16'd1, 22'h000001, 16'd1, 12'd0, 12'd1, 12'd8);
        push_pixels(2);                      // replaces it, second pixel has no column
        settle();

        // register extremes
        set_registers(32'h3FFFFF, 0, 1024, 1024, 4095);
        run_columns(130);
        settle();
        set_registers(0, 32'h3FFFFF, 1, 1, 1);
        run_columns(120);
        settle();

        // zero width and zero height
        set_registers($urandom_range(0, 32'h3FFFFF), $urandom_range(0, 32'h3FFFFF),
                      0, 0, $urandom_range(1, 4095));
        run_columns(100);
        settle();

        // odd height, not a power of two
        set_registers($urandom_range(0, 32'h3FFFFF), $urandom_range(0, 32'h3FFFFF),
                      $urandom_range(1, 1024), ($urandom_range(1, 511) << 1) | 1,
                      $urandom_range(1, 4095));
        run_columns(120);
        settle();

        // usual power-of-two texture heights
        set_registers($urandom_range(0, 32'h3FFFFF), $urandom_range(0, 32'h3FFFFF),
                      $urandom_range(1, 1024), 1 << $urandom_range(0, 10),
                      $urandom_range(1, 4095));
        run_columns(170);
        settle();
        set_registers($urandom_range(0, 32'h3FFFFF), $urandom_range(0, 32'h3FFFFF),
                      $urandom_range(1, 1024), 1 << $urandom_range(0, 10),
                      $urandom_range(1, 4095));
        run_columns(90);
        idling_on = 1'b0;                    // full rate to the end
        run_columns(90);
        settle();

        if (board.pending.size() != 0) begin
            $error("%0d expected result beats never arrived", board.pending.size());
            board.fails++;
        end
        if (board.fails == 0) begin
            $display("raycast_wall_texel_addresser_unit test passed");
        end else begin
            $display("raycast_wall_texel_addresser_unit test failed");
        end
        $finish;
    end

endmodule
